// File: src/dkt_pkg.sv
// Shared types and constants for the difference-of-Gaussians tap pipeline.
package dkt_pkg;

  localparam logic [2:0] REG_CENTER_WEIGHT   = 3'd0;
  localparam logic [2:0] REG_CENTER_RATE     = 3'd1;
  localparam logic [2:0] REG_SURROUND_WEIGHT = 3'd2;
  localparam logic [2:0] REG_SURROUND_RATE   = 3'd3;
  localparam logic [2:0] REG_OFF_CENTER      = 3'd4;

  localparam logic [15:0] RST_CENTER_WEIGHT   = 16'd4096;
  localparam logic [15:0] RST_CENTER_RATE     = 16'd25600;
  localparam logic [15:0] RST_SURROUND_WEIGHT = 16'd1229;
  localparam logic [15:0] RST_SURROUND_RATE   = 16'd5120;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [32:0] Q32_ONE   = 33'h1_0000_0000;

  localparam int TAB_DEPTH = 12;
  localparam logic [31:0] POW2_NEG_TAB [0:TAB_DEPTH-1] = '{
    32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874773,
    32'd4202935003, 32'd4248701965, 32'd4271771996, 32'd4283353945,
    32'd4289156690, 32'd4292061010, 32'd4293513907, 32'd4294240540
  };

  typedef struct packed {
    logic signed [15:0] center_weight;
    logic [15:0]        center_rate;
    logic signed [15:0] surround_weight;
    logic [15:0]        surround_rate;
    logic               off_center;
  } cfg_t;

endpackage

// File: src/dkt_exp.sv
// Pipelined exp(-rate * r2) in Q1.32 by range reduction and a table of powers of two.
module dkt_exp #(
  parameter int TABLE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [15:0] rate,
  input  logic [31:0] r2,
  output logic        out_valid,
  output logic [32:0] e
);

  localparam int RW  = 32 - TABLE_BITS;
  localparam int CPW = RW + 32;

  logic        v1_r, v2_r, vc_r, ve_r;
  logic [47:0] t_r;
  logic        big_r;
  logic [37:0] u_r;
  logic [32:0] mc_r, e_r;
  logic        zc_r;
  logic [4:0]  nc_r;

  logic              v_r    [0:TABLE_BITS];
  logic [32:0]       m_r    [0:TABLE_BITS];
  logic [32:0]       fac_r  [0:TABLE_BITS];
  logic              zero_r [0:TABLE_BITS];
  logic [4:0]        n_r    [0:TABLE_BITS];
  logic [TABLE_BITS-1:0] fhi_r [0:TABLE_BITS];

  logic [47:0]  t_nxt;
  logic [53:0]  u_full;
  logic [CPW-1:0] cprod;
  logic [32:0]  fac_nxt;
  logic [64:0]  tprod [1:TABLE_BITS];
  logic [65:0]  fprod;
  logic [32:0]  e_nxt;

  always_comb begin
    t_nxt   = 48'(rate) * 48'(r2);
    u_full  = 54'(t_r[36:0]) * 54'(dkt_pkg::LOG2E_Q16);
    cprod   = CPW'(u_r[RW-1:0]) * CPW'(dkt_pkg::LN2_Q32);
    fac_nxt = dkt_pkg::Q32_ONE - 33'(cprod[CPW-1:32]);
    for (int i = 1; i <= TABLE_BITS; i++) begin
      tprod[i] = 65'(m_r[i-1]) * 65'(dkt_pkg::POW2_NEG_TAB[i-1]);
    end
    fprod = 66'(m_r[TABLE_BITS]) * 66'(fac_r[TABLE_BITS]);
    e_nxt = zc_r ? 33'd0 : (mc_r >> nc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vc_r <= 1'b0;
      ve_r <= 1'b0;
      for (int i = 0; i <= TABLE_BITS; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v_r[0] <= v2_r;
      for (int i = 1; i <= TABLE_BITS; i++) begin
        v_r[i] <= v_r[i-1];
      end
      vc_r <= v_r[TABLE_BITS];
      ve_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    big_r     <= |t_r[47:37];
    u_r       <= u_full[53:16];
    m_r[0]    <= dkt_pkg::Q32_ONE;
    fac_r[0]  <= fac_nxt;
    zero_r[0] <= big_r | u_r[37];
    n_r[0]    <= u_r[36:32];
    fhi_r[0]  <= u_r[31:RW];
    for (int i = 1; i <= TABLE_BITS; i++) begin
      m_r[i]    <= fhi_r[i-1][TABLE_BITS-i] ? tprod[i][64:32] : m_r[i-1];
      fac_r[i]  <= fac_r[i-1];
      zero_r[i] <= zero_r[i-1];
      n_r[i]    <= n_r[i-1];
      fhi_r[i]  <= fhi_r[i-1];
    end
    mc_r <= fprod[64:32];
    zc_r <= zero_r[TABLE_BITS];
    nc_r <= n_r[TABLE_BITS];
    e_r  <= e_nxt;
  end

  assign out_valid = ve_r;
  assign e         = e_r;

endmodule

// File: src/dkt_mix.sv
// Weighted difference of the two Gaussians, rounding, polarity and saturation.
module dkt_mix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [32:0]        ec,
  input  logic [32:0]        es,
  input  dkt_pkg::cfg_t      cfg,
  output logic               out_valid,
  output logic signed [15:0] tap
);

  logic               vp_r, vd_r, vq_r;
  logic signed [49:0] pc_r, ps_r, d_r;
  logic signed [15:0] tap_r;

  logic signed [49:0] pc_nxt, ps_nxt;
  logic signed [18:0] q, qn;
  logic signed [15:0] tap_nxt;

  always_comb begin
    pc_nxt = 50'(cfg.center_weight) * 50'($signed({1'b0, ec}));
    ps_nxt = 50'(cfg.surround_weight) * 50'($signed({1'b0, es}));
    q      = $signed({d_r[49], d_r[49:32]}) + $signed({18'd0, d_r[31]});
    qn     = cfg.off_center ? -q : q;
    if (qn > 19'sd32767) begin
      tap_nxt = 16'sh7FFF;
    end else if (qn < -19'sd32768) begin
      tap_nxt = 16'sh8000;
    end else begin
      tap_nxt = qn[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
      vd_r <= 1'b0;
      vq_r <= 1'b0;
    end else begin
      vp_r <= in_valid;
      vd_r <= vp_r;
      vq_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    pc_r  <= pc_nxt;
    ps_r  <= ps_nxt;
    d_r   <= pc_r - ps_r;
    tap_r <= tap_nxt;
  end

  assign out_valid = vq_r;
  assign tap       = tap_r;

endmodule

// File: src/dog_kernel_tap.sv
// Top level: difference-of-Gaussians kernel tap, one result per coordinate pair.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   in       | start, busy          | in_x_coord, in_y_coord
//   out      | out_valid (strobe)   | out_tap_value
//   cfg      | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// A request is taken every cycle; busy and cfg_ready are constant.
// A result passes through the squared-radius registers, the exponential pipeline
// (which grows with the table bits) and the weighted-difference registers.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// The receiver cannot stall, so the pipeline advances every cycle.
module dog_kernel_tap #(
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_x_coord,
  input  logic signed [15:0] in_y_coord,
  output logic               out_valid,
  output logic signed [15:0] out_tap_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  dkt_pkg::cfg_t cfg_r, cfg_nxt;

  logic        va_r, vb_r;
  logic [31:0] xx_r, yy_r, r2_r;
  logic signed [31:0] xx_nxt, yy_nxt;

  logic        vc, vs;
  logic [32:0] ec, es;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        dkt_pkg::REG_CENTER_WEIGHT:   cfg_nxt.center_weight   = cfg_data;
        dkt_pkg::REG_CENTER_RATE:     cfg_nxt.center_rate     = cfg_data;
        dkt_pkg::REG_SURROUND_WEIGHT: cfg_nxt.surround_weight = cfg_data;
        dkt_pkg::REG_SURROUND_RATE:   cfg_nxt.surround_rate   = cfg_data;
        dkt_pkg::REG_OFF_CENTER:      cfg_nxt.off_center      = cfg_data[0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
    xx_nxt = 32'(in_x_coord) * 32'(in_x_coord);
    yy_nxt = 32'(in_y_coord) * 32'(in_y_coord);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_weight   <= dkt_pkg::RST_CENTER_WEIGHT;
      cfg_r.center_rate     <= dkt_pkg::RST_CENTER_RATE;
      cfg_r.surround_weight <= dkt_pkg::RST_SURROUND_WEIGHT;
      cfg_r.surround_rate   <= dkt_pkg::RST_SURROUND_RATE;
      cfg_r.off_center      <= 1'b0;
      va_r                  <= 1'b0;
      vb_r                  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      va_r  <= start & ~busy;
      vb_r  <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    xx_r <= xx_nxt;
    yy_r <= yy_nxt;
    r2_r <= xx_r + yy_r;
  end

  dkt_exp #(
    .TABLE_BITS (EXP_TABLE_BITS)
  ) u_exp_center (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vb_r),
    .rate      (cfg_r.center_rate),
    .r2        (r2_r),
    .out_valid (vc),
    .e         (ec)
  );

  dkt_exp #(
    .TABLE_BITS (EXP_TABLE_BITS)
  ) u_exp_surround (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vb_r),
    .rate      (cfg_r.surround_rate),
    .r2        (r2_r),
    .out_valid (vs),
    .e         (es)
  );

  dkt_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vc & vs),
    .ec        (ec),
    .es        (es),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .tap       (out_tap_value)
  );

endmodule

// File: test/tb_dog_kernel_tap.sv
// Testbench for dog_kernel_tap: directed and random coordinate requests checked against a tap predictor.
module tb_dog_kernel_tap;

  localparam int TABLE_BITS  = 8;
  localparam int LATENCY     = 10 + TABLE_BITS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 40;

  localparam logic [63:0] Q32_UNIT    = 64'h1_0000_0000;
  localparam logic [63:0] DECAY_LIMIT = 64'd137438953472;
  localparam logic [63:0] LOG2E_FIX   = 64'd94548;
  localparam logic [63:0] LN2_FIX     = 64'd2977044472;
  localparam logic [63:0] HALF_POW_Q32 [12] = '{
    64'd3037000500, 64'd3611622603, 64'd3938502376, 64'd4112874773,
    64'd4202935003, 64'd4248701965, 64'd4271771996, 64'd4283353945,
    64'd4289156690, 64'd4292061010, 64'd4293513907, 64'd4294240540
  };

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] tap;
  } tap_req_t;

  class tap_scoreboard;
    logic signed [15:0] center_weight;
    logic [15:0]        center_rate;
    logic signed [15:0] surround_weight;
    logic [15:0]        surround_rate;
    logic               off_center;
    tap_req_t           taps_due[$];
    int                 mismatches;
    int                 checked;
    int                 requests;
    int                 writes;

    function new();
      center_weight   = 16'sd4096;
      center_rate     = 16'd25600;
      surround_weight = 16'sd1229;
      surround_rate   = 16'd5120;
      off_center      = 1'b0;
      mismatches      = 0;
      checked         = 0;
      requests        = 0;
      writes          = 0;
    endfunction

    function void apply_write(logic [2:0] idx, logic [15:0] data);
      writes++;
      case (idx)
        dkt_pkg::REG_CENTER_WEIGHT:   center_weight   = data;
        dkt_pkg::REG_CENTER_RATE:     center_rate     = data;
        dkt_pkg::REG_SURROUND_WEIGHT: surround_weight = data;
        dkt_pkg::REG_SURROUND_RATE:   surround_rate   = data;
        dkt_pkg::REG_OFF_CENTER:      off_center      = data[0];
        default: ;
      endcase
    endfunction

    // exp(-rate * r2) in Q1.32, via 2^-(t*log2 e)
    function logic [63:0] decay_q32(logic [15:0] rate, logic [63:0] r2);
      logic [63:0] t;
      logic [63:0] u;
      logic [63:0] f;
      logic [63:0] m;
      logic [63:0] r;
      logic [63:0] n;
      int          nbits;
      t = {48'd0, rate} * r2;
      if (t >= DECAY_LIMIT) return 64'd0;
      u = (t * LOG2E_FIX) >> 16;
      n = u >> 32;
      f = {32'd0, u[31:0]};
      nbits = (TABLE_BITS > 12) ? 12 : TABLE_BITS;
      m = Q32_UNIT;
      for (int i = 1; i <= nbits; i++) begin
        if (f[32-i]) m = (m * HALF_POW_Q32[i-1]) >> 32;
      end
      r = f & ((64'd1 << (32 - nbits)) - 64'd1);
      if (r != 64'd0) m = (m * (Q32_UNIT - ((r * LN2_FIX) >> 32))) >> 32;
      if (n >= 64'd32) return 64'd0;
      return m >> n;
    endfunction

    function logic signed [15:0] predict_tap(logic signed [15:0] x, logic signed [15:0] y);
      longint      xs;
      longint      ys;
      longint      d;
      longint      q;
      logic [63:0] r2;
      logic [63:0] ec;
      logic [63:0] es;
      xs = x;
      ys = y;
      r2 = xs * xs + ys * ys;
      ec = decay_q32(center_rate, r2);
      es = decay_q32(surround_rate, r2);
      d = longint'(center_weight) * longint'(ec) - longint'(surround_weight) * longint'(es);
      q = (d + (longint'(1) <<< 31)) >>> 32;
      if (off_center) q = -q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function void note_request(logic signed [15:0] x, logic signed [15:0] y);
      tap_req_t req;
      req.x   = x;
      req.y   = y;
      req.tap = predict_tap(x, y);
      taps_due.push_back(req);
      requests++;
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("ERROR: %s", msg);
    endtask

    task check_tap(input logic signed [15:0] got);
      tap_req_t req;
      checked++;
      if (taps_due.size() == 0) begin
        report_mismatch($sformatf("tap_value %0d with no request outstanding", got));
      end else begin
        req = taps_due.pop_front();
        if (got !== req.tap)
          report_mismatch($sformatf("tap_value got %0d expected %0d (x=%0d y=%0d)",
                                    got, req.tap, req.x, req.y));
      end
    endtask

    function int pending();
      return taps_due.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] in_x_coord = '0;
  logic signed [15:0] in_y_coord = '0;
  logic               out_valid;
  logic signed [15:0] out_tap_value;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  tap_scoreboard sb;
  int            idle_pct = 0;
  int            cycles = 0;

  dog_kernel_tap #(
    .EXP_TABLE_BITS(TABLE_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .out_valid     (out_valid),
    .out_tap_value (out_tap_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d taps outstanding", cycles, sb.pending());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_tap(out_tap_value);
  end

  task automatic send_coord(input logic [15:0] x, input logic [15:0] y);
    while ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_x_coord <= x;
    in_y_coord <= y;
    do @(posedge clk); while (busy);
    sb.note_request(x, y);
  endtask

  task automatic stop_requests();
    start <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_write(idx, data);
  endtask

  task automatic end_cfg();
    cfg_valid <= 1'b0;
  endtask

  task automatic load_cfg(input logic [15:0] cw, input logic [15:0] cr, input logic [15:0] sw,
                          input logic [15:0] sr, input logic [15:0] oc);
    write_reg(dkt_pkg::REG_CENTER_WEIGHT, cw);
    write_reg(dkt_pkg::REG_CENTER_RATE, cr);
    write_reg(dkt_pkg::REG_SURROUND_WEIGHT, sw);
    write_reg(dkt_pkg::REG_SURROUND_RATE, sr);
    write_reg(dkt_pkg::REG_OFF_CENTER, oc);
    end_cfg();
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom_range(0, 4095)) - 16'd2048;
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_rate();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 8191));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: radius extremes and near-center points
    send_coord(16'h0000, 16'h0000);
    send_coord(16'h7FFF, 16'h7FFF);
    send_coord(16'h8000, 16'h8000);
    send_coord(16'h7FFF, 16'h8000);
    send_coord(16'h8000, 16'h0000);
    send_coord(16'h0000, 16'h7FFF);
    send_coord(16'h0001, 16'h0000);
    send_coord(16'h0000, 16'hFFFF);
    send_coord(16'h0400, 16'h0000);
    send_coord(16'h0000, 16'hF800);
    send_coord(16'h05A8, 16'h05A8);
    send_coord(16'hF000, 16'h1000);
    stop_requests();
    wait_drained();

    // zero rates with extreme weights: saturate low in off-center mode
    load_cfg(16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 16'h0001);
    send_coord(16'h0000, 16'h0000);
    send_coord(16'h7FFF, 16'h8000);
    stop_requests();
    wait_drained();

    // drop upper off-center bits, ignore writes past the last register
    write_reg(dkt_pkg::REG_OFF_CENTER, 16'hFFFE);
    for (int k = dkt_pkg::REG_OFF_CENTER + 1; k < 8; k++) write_reg(3'(k), 16'($urandom));
    end_cfg();
    send_coord(16'h0000, 16'h0000);
    send_coord(16'hFFFB, 16'h0007);
    stop_requests();
    wait_drained();

    // maximum rates: the largest radius decays to zero, smaller radii do not
    load_cfg(16'h8000, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h0000);
    send_coord(16'h7FFF, 16'h7FFF);
    send_coord(16'h0001, 16'h0000);
    send_coord(16'h0000, 16'h0010);
    send_coord(16'h0100, 16'hFF00);
    stop_requests();
    wait_drained();

    for (int seg = 0; seg < 8; seg++) begin
      idle_pct = (seg < 3) ? 17 : ((seg < 6) ? 81 : 0);
      load_cfg(pick_weight(), pick_rate(), pick_weight(), pick_rate(),
               {15'($urandom), 1'($urandom_range(0, 1))});
      for (int k = 0; k < 100; k++) begin
        if (seg == 4 && k == 50) begin
          stop_requests();
          wait_drained();
        end
        send_coord(rand_coord(), rand_coord());
      end
      stop_requests();
      wait_drained();
    end

    repeat (LATENCY + 4) @(posedge clk);
    $display("Checked %0d taps from %0d coordinate requests across %0d register writes,",
             sb.checked, sb.requests, sb.writes);
    $display("covering zero and maximum rates, saturation, off-center mode and three pacings.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
src/dkt_pkg.sv
src/dkt_exp.sv
src/dkt_mix.sv
src/dog_kernel_tap.sv
test/tb_dog_kernel_tap.sv
